FILE: src/rdc_pkg.sv
// Shared constants, codes and controller/datapath interface types for range_distinct_count.
package rdc_pkg;

    localparam int ELEMENT_DEPTH = 1024;
    localparam int VALUE_RANGE   = 1024;

    // Field widths of the transfer payload.
    localparam int IDX_W   = 10;
    localparam int VALUE_W = 10;
    localparam int TAG_W   = 16;

    localparam int ELEM_AW = $clog2(ELEMENT_DEPTH);
    localparam int VAL_AW  = $clog2(VALUE_RANGE);
    localparam int POS_W   = $clog2(ELEMENT_DEPTH) + 1;
    localparam int COUNT_W = $clog2(ELEMENT_DEPTH + 1);

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef enum logic [2:0] {
        OP_GROW_LEFT,
        OP_GROW_RIGHT,
        OP_SHRINK_LEFT,
        OP_SHRINK_RIGHT,
        OP_LOAD_LEAVE,
        OP_LOAD_ENTER
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_COUNT_RD,
        ST_UPDATE,
        ST_ANSWER
    } state_t;

    typedef struct packed {
        logic capture;
        logic elem_rd;
        logic elem_wr;
        logic occ_rd;
        logic update;
        logic clr_wr;
        logic out_load;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_load;
        logic load_ok;
        logic in_window;
        logic inverted;
        logic start_gt_lo;
        logic end_lt_stop;
        logic start_lt_lo;
        logic end_gt_stop;
        logic clr_last;
        logic out_free;
    } ctrl_status_t;

endpackage

FILE: src/rdc_ctrl.sv
// Sequencing state machine for range_distinct_count.
module rdc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rdc_pkg::ctrl_status_t st,
    output rdc_pkg::ctrl_cmd_t    cmd
);

    rdc_pkg::state_t state_reg, state_next;
    rdc_pkg::op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdc_pkg::ST_CLEAR;
            op_reg    <= rdc_pkg::OP_GROW_LEFT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        in_ready   = 1'b0;
        case (state_reg)
            rdc_pkg::ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = rdc_pkg::ST_IDLE;
                end
            end
            rdc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = rdc_pkg::ST_DECIDE;
                end
            end
            rdc_pkg::ST_DECIDE:
            begin
                if (st.is_load)
                begin
                    if (!st.load_ok)
                    begin
                        state_next = rdc_pkg::ST_IDLE;
                    end
                    else if (st.in_window)
                    begin
                        // The old value leaves the counts before the new one enters.
                        cmd.op      = rdc_pkg::OP_LOAD_LEAVE;
                        cmd.elem_rd = 1'b1;
                        op_next     = rdc_pkg::OP_LOAD_LEAVE;
                        state_next  = rdc_pkg::ST_COUNT_RD;
                    end
                    else
                    begin
                        cmd.elem_wr = 1'b1;
                        state_next  = rdc_pkg::ST_IDLE;
                    end
                end
                else if (st.inverted)
                begin
                    state_next = rdc_pkg::ST_ANSWER;
                end
                else if (st.start_gt_lo || st.end_lt_stop || st.start_lt_lo || st.end_gt_stop)
                begin
                    // Growing moves take priority so that no count can underflow.
                    if (st.start_gt_lo)
                    begin
                        cmd.op = rdc_pkg::OP_GROW_LEFT;
                    end
                    else if (st.end_lt_stop)
                    begin
                        cmd.op = rdc_pkg::OP_GROW_RIGHT;
                    end
                    else if (st.start_lt_lo)
                    begin
                        cmd.op = rdc_pkg::OP_SHRINK_LEFT;
                    end
                    else
                    begin
                        cmd.op = rdc_pkg::OP_SHRINK_RIGHT;
                    end
                    cmd.elem_rd = 1'b1;
                    op_next     = cmd.op;
                    state_next  = rdc_pkg::ST_COUNT_RD;
                end
                else
                begin
                    state_next = rdc_pkg::ST_ANSWER;
                end
            end
            rdc_pkg::ST_COUNT_RD:
            begin
                cmd.occ_rd = 1'b1;
                state_next = rdc_pkg::ST_UPDATE;
            end
            rdc_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                case (op_reg)
                    rdc_pkg::OP_LOAD_LEAVE:
                    begin
                        cmd.elem_wr = 1'b1;
                        op_next     = rdc_pkg::OP_LOAD_ENTER;
                        state_next  = rdc_pkg::ST_COUNT_RD;
                    end
                    rdc_pkg::OP_LOAD_ENTER:
                    begin
                        state_next = rdc_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next = rdc_pkg::ST_DECIDE;
                    end
                endcase
            end
            rdc_pkg::ST_ANSWER:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/rdc_datapath.sv
// Element and occurrence memories, window pointers, distinct total and result register.
module rdc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rdc_pkg::ctrl_cmd_t                    cmd,
    output rdc_pkg::ctrl_status_t                 st,
    input  logic                                  action,
    input  logic [rdc_pkg::IDX_W-1:0]             load_index,
    input  logic [rdc_pkg::VALUE_W-1:0]           load_value,
    input  logic [rdc_pkg::IDX_W-1:0]             left_bound,
    input  logic [rdc_pkg::IDX_W-1:0]             right_bound,
    input  logic [rdc_pkg::TAG_W-1:0]             query_tag,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rdc_pkg::TAG_W-1:0]             answer_tag,
    output logic [rdc_pkg::COUNT_W-1:0]           distinct_count
);

    localparam int POS_W   = rdc_pkg::POS_W;
    localparam int COUNT_W = rdc_pkg::COUNT_W;
    localparam int ELEM_AW = rdc_pkg::ELEM_AW;
    localparam int VAL_AW  = rdc_pkg::VAL_AW;
    localparam int VALUE_W = rdc_pkg::VALUE_W;

    logic [VALUE_W-1:0] elem_mem [rdc_pkg::ELEMENT_DEPTH];
    logic [COUNT_W-1:0] occ_mem  [rdc_pkg::VALUE_RANGE];

    // Captured item.
    logic                       is_load_reg;
    logic                       load_ok_reg;
    logic                       inverted_reg;
    logic [ELEM_AW-1:0]         idx_reg;
    logic [VALUE_W-1:0]         val_reg;
    logic [POS_W-1:0]           lo_reg;
    logic [POS_W-1:0]           stop_reg;
    logic [rdc_pkg::TAG_W-1:0]  tag_reg;

    logic [POS_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   end_reg, end_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [VAL_AW-1:0]  clr_addr_reg;

    logic [VALUE_W-1:0] elem_rdata_reg;
    logic [COUNT_W-1:0] occ_rdata_reg;
    logic [VALUE_W-1:0] value_reg;

    logic                       out_valid_reg;
    logic [rdc_pkg::TAG_W-1:0]  answer_tag_reg;
    logic [COUNT_W-1:0]         count_reg;

    logic [POS_W-1:0]   hi_sat;
    logic [POS_W-1:0]   rd_pos;
    logic [VALUE_W-1:0] step_value;
    logic               leaving;
    logic               occ_zero;
    logic               occ_we;
    logic [VAL_AW-1:0]  occ_waddr;
    logic [COUNT_W-1:0] occ_wdata;

    always_comb
    begin
        if (right_bound >= rdc_pkg::ELEMENT_DEPTH)
        begin
            hi_sat = POS_W'(rdc_pkg::ELEMENT_DEPTH - 1);
        end
        else
        begin
            hi_sat = POS_W'(right_bound);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_load_reg  <= (action == rdc_pkg::ACTION_LOAD);
            load_ok_reg  <= (load_index < rdc_pkg::ELEMENT_DEPTH)
                            && (load_value < rdc_pkg::VALUE_RANGE);
            inverted_reg <= (hi_sat < left_bound);
            idx_reg      <= ELEM_AW'(load_index);
            val_reg      <= load_value;
            lo_reg       <= POS_W'(left_bound);
            stop_reg     <= hi_sat + POS_W'(1);
            tag_reg      <= query_tag;
        end
    end

    always_comb
    begin
        st.is_load     = is_load_reg;
        st.load_ok     = load_ok_reg;
        st.in_window   = (POS_W'(idx_reg) >= start_reg) && (POS_W'(idx_reg) < end_reg);
        st.inverted    = inverted_reg;
        st.start_gt_lo = start_reg > lo_reg;
        st.end_lt_stop = end_reg < stop_reg;
        st.start_lt_lo = start_reg < lo_reg;
        st.end_gt_stop = end_reg > stop_reg;
        st.clr_last    = clr_addr_reg == VAL_AW'(rdc_pkg::VALUE_RANGE - 1);
        st.out_free    = !out_valid_reg || out_ready;
    end

    // Element store: one read and one write port.
    always_comb
    begin
        case (cmd.op)
            rdc_pkg::OP_GROW_LEFT:    rd_pos = start_reg - POS_W'(1);
            rdc_pkg::OP_GROW_RIGHT:   rd_pos = end_reg;
            rdc_pkg::OP_SHRINK_LEFT:  rd_pos = start_reg;
            rdc_pkg::OP_SHRINK_RIGHT: rd_pos = end_reg - POS_W'(1);
            default:                  rd_pos = POS_W'(idx_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.elem_rd)
        begin
            elem_rdata_reg <= elem_mem[rd_pos[ELEM_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.elem_wr)
        begin
            elem_mem[idx_reg] <= val_reg;
        end
    end

    // Occurrence store: read the count, then write it back adjusted.
    assign step_value = (cmd.op == rdc_pkg::OP_LOAD_ENTER) ? val_reg : elem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.occ_rd)
        begin
            value_reg     <= step_value;
            occ_rdata_reg <= occ_mem[VAL_AW'(step_value)];
        end
    end

    assign leaving  = (cmd.op == rdc_pkg::OP_SHRINK_LEFT) || (cmd.op == rdc_pkg::OP_SHRINK_RIGHT)
                      || (cmd.op == rdc_pkg::OP_LOAD_LEAVE);
    assign occ_zero = occ_rdata_reg == '0;

    always_comb
    begin
        occ_we    = 1'b0;
        occ_waddr = VAL_AW'(value_reg);
        occ_wdata = occ_rdata_reg + COUNT_W'(1);
        if (cmd.clr_wr)
        begin
            occ_we    = 1'b1;
            occ_waddr = clr_addr_reg;
            occ_wdata = '0;
        end
        else if (cmd.update)
        begin
            // A count already at zero is left alone when its element leaves.
            occ_we = !(leaving && occ_zero);
            if (leaving)
            begin
                occ_wdata = occ_rdata_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
    end

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        total_next = total_reg;
        if (cmd.update)
        begin
            case (cmd.op)
                rdc_pkg::OP_GROW_LEFT:    start_next = start_reg - POS_W'(1);
                rdc_pkg::OP_GROW_RIGHT:   end_next   = end_reg + POS_W'(1);
                rdc_pkg::OP_SHRINK_LEFT:  start_next = start_reg + POS_W'(1);
                rdc_pkg::OP_SHRINK_RIGHT: end_next   = end_reg - POS_W'(1);
                default:                  start_next = start_reg;
            endcase
            if (leaving)
            begin
                if (occ_rdata_reg == COUNT_W'(1))
                begin
                    total_next = total_reg - COUNT_W'(1);
                end
            end
            else if (occ_zero)
            begin
                total_next = total_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            end_reg       <= '0;
            total_reg     <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
            total_reg <= total_next;
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + VAL_AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            answer_tag_reg <= tag_reg;
            count_reg      <= inverted_reg ? '0 : total_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign answer_tag     = answer_tag_reg;
    assign distinct_count = count_reg;

endmodule

FILE: src/range_distinct_count.sv
// Top level of range_distinct_count: controller and datapath joined by command and status.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  in      | input     | in_valid/in_ready  | action, load_index, load_value, left_bound,
//          |           |                    | right_bound, query_tag
//  out     | output    | out_valid/out_ready| answer_tag, distinct_count
//
// One item at a time. A load outside the window only writes its element; one inside it also
// updates the counts (the old value leaves them and the new one enters). A valid query moves
// the window element by element to its range; each move is an element read, a count read and a write.
// After reset a clearing pass writes the 1024 occurrence counts, one a cycle, and in_ready
// stays low until the pass ends. An answer waits in the output register; a stalled output
// holds back only a query that is ready to deliver its transfer.
module range_distinct_count (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [rdc_pkg::IDX_W-1:0]     load_index,
    input  logic [rdc_pkg::VALUE_W-1:0]   load_value,
    input  logic [rdc_pkg::IDX_W-1:0]     left_bound,
    input  logic [rdc_pkg::IDX_W-1:0]     right_bound,
    input  logic [rdc_pkg::TAG_W-1:0]     query_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rdc_pkg::TAG_W-1:0]     answer_tag,
    output logic [rdc_pkg::COUNT_W-1:0]   distinct_count
);

    rdc_pkg::ctrl_cmd_t    cmd;
    rdc_pkg::ctrl_status_t st;

    rdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    rdc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .action         (action),
        .load_index     (load_index),
        .load_value     (load_value),
        .left_bound     (left_bound),
        .right_bound    (right_bound),
        .query_tag      (query_tag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .answer_tag     (answer_tag),
        .distinct_count (distinct_count)
    );

endmodule

FILE: bench/tb_top.sv
// Testbench for range_distinct_count: loads and range queries checked against a window predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASE_ITEMS  = 333;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 64;
    localparam longint TIMEOUT_NS = 64'd100_000_000;

    typedef logic [rdc_pkg::IDX_W-1:0]   idx_t;
    typedef logic [rdc_pkg::VALUE_W-1:0] value_t;
    typedef logic [rdc_pkg::TAG_W-1:0]   tag_t;
    typedef logic [rdc_pkg::COUNT_W-1:0] count_t;

    typedef struct {
        tag_t   tag;
        count_t count;
    } answer_t;

    // Mirrors the block's element store, occurrence counts and sliding window.
    class distinct_scoreboard;
        bit [rdc_pkg::VALUE_W-1:0] element_value [rdc_pkg::ELEMENT_DEPTH];
        int unsigned               value_hits [rdc_pkg::VALUE_RANGE];
        int unsigned               distinct_now;
        int unsigned               win_lo;
        int unsigned               win_end;
        answer_t                   pending_answers [$];
        int unsigned               mismatches;

        function void count_in(int unsigned pos);
            int unsigned v;
            v = element_value[pos];
            value_hits[v]++;
            if (value_hits[v] == 1)
                distinct_now++;
        endfunction

        function void count_out(int unsigned pos);
            int unsigned v;
            v = element_value[pos];
            if (value_hits[v] == 0)
                return;
            value_hits[v]--;
            if (value_hits[v] == 0)
                distinct_now--;
        endfunction

        function void note_transfer(logic act, idx_t idx, value_t val, idx_t lo,
                                    idx_t hi, tag_t tag);
            answer_t     exp;
            int unsigned lo_u;
            int unsigned stop;
            if (act == rdc_pkg::ACTION_LOAD)
            begin
                // A load inside the window swaps the old value out of the counts.
                if (idx >= win_lo && idx < win_end)
                begin
                    count_out(idx);
                    element_value[idx] = val;
                    count_in(idx);
                end
                else
                begin
                    element_value[idx] = val;
                end
                return;
            end
            exp.tag = tag;
            if (hi < lo)
            begin
                exp.count = '0;
            end
            else
            begin
                lo_u = lo;
                stop = hi + 1;
                while (win_lo > lo_u)
                begin
                    win_lo--;
                    count_in(win_lo);
                end
                while (win_end < stop)
                begin
                    count_in(win_end);
                    win_end++;
                end
                while (win_lo < lo_u)
                begin
                    count_out(win_lo);
                    win_lo++;
                end
                while (win_end > stop)
                begin
                    win_end--;
                    count_out(win_end);
                end
                exp.count = count_t'(distinct_now);
            end
            pending_answers.push_back(exp);
        endfunction

        function void check_answer(tag_t tag, count_t count);
            answer_t exp;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("answer with none expected: tag %h count %0d", tag, count);
                return;
            end
            exp = pending_answers.pop_front();
            if (tag !== exp.tag || count !== exp.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("answer mismatch: tag exp %h got %h, count exp %0d got %0d",
                             exp.tag, tag, exp.count, count);
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    logic   action;
    idx_t   load_index;
    value_t load_value;
    idx_t   left_bound;
    idx_t   right_bound;
    tag_t   query_tag;
    logic   out_valid;
    logic   out_ready;
    tag_t   answer_tag;
    count_t distinct_count;

    distinct_scoreboard sb = new();

    int   tx_idle_pct;
    int   rx_idle_pct;
    logic hold_request;

    // Stimulus-side view: which elements are loaded and where the window will sit.
    bit written [rdc_pkg::ELEMENT_DEPTH];
    int filled;
    int next_lo;
    int next_stop;

    range_distinct_count DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .load_index     (load_index),
        .load_value     (load_value),
        .left_bound     (left_bound),
        .right_bound    (right_bound),
        .query_tag      (query_tag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .answer_tag     (answer_tag),
        .distinct_count (distinct_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, with one long hold-off on request.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_answer(answer_tag, distinct_count);
    end

    task automatic send_item(input logic act, input idx_t idx, input value_t val,
                             input idx_t lo, input idx_t hi, input tag_t tag);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        load_index  <= idx;
        load_value  <= val;
        left_bound  <= lo;
        right_bound <= hi;
        query_tag   <= tag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_transfer(act, idx, val, lo, hi, tag);
    endtask

    // Unused fields of each transfer carry random bits.
    task automatic load_element(input int idx, input int val);
        send_item(rdc_pkg::ACTION_LOAD, idx_t'(idx), value_t'(val),
                  idx_t'($urandom_range(0, rdc_pkg::ELEMENT_DEPTH - 1)),
                  idx_t'($urandom_range(0, rdc_pkg::ELEMENT_DEPTH - 1)),
                  tag_t'($urandom_range(0, 65535)));
        written[idx] = 1'b1;
        while (filled < rdc_pkg::ELEMENT_DEPTH && written[filled])
            filled++;
    endtask

    task automatic ask_range(input int lo, input int hi, input int tag);
        send_item(rdc_pkg::ACTION_QUERY,
                  idx_t'($urandom_range(0, rdc_pkg::ELEMENT_DEPTH - 1)),
                  value_t'($urandom_range(0, rdc_pkg::VALUE_RANGE - 1)),
                  idx_t'(lo), idx_t'(hi), tag_t'(tag));
        if (hi >= lo)
        begin
            next_lo   = lo;
            next_stop = hi + 1;
        end
    endtask

    task automatic wait_for_answers();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_answers.size() != 0);
    endtask

    function automatic int clamp_index(input int v, input int top);
        if (v < 0)
            return 0;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 3);
        // Mostly a small pool, so that ranges hold repeated values.
        if (r < 2)
            return $urandom_range(0, 15);
        if (r == 2)
            return $urandom_range(0, rdc_pkg::VALUE_RANGE - 1);
        return $urandom_range(0, 1) ? rdc_pkg::VALUE_RANGE - 1 : 0;
    endfunction

    // Queries only ever walk the window over loaded elements: valid ranges stay
    // inside the loaded prefix, which also holds the current window.
    task automatic random_item();
        int pick;
        int r;
        int lo;
        int hi;
        int t;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            r = $urandom_range(0, 99);
            if (r < 55 && filled < rdc_pkg::ELEMENT_DEPTH)
                load_element(filled, pick_value());
            else if (r < 75 && next_stop > next_lo)
                load_element($urandom_range(next_lo, next_stop - 1), pick_value());
            else
                load_element($urandom_range(0, rdc_pkg::ELEMENT_DEPTH - 1), pick_value());
        end
        else if (pick < 58)
        begin
            lo = $urandom_range(1, rdc_pkg::ELEMENT_DEPTH - 1);
            hi = $urandom_range(0, lo - 1);
            ask_range(lo, hi, $urandom_range(0, 65535));
        end
        else
        begin
            if (pick < 66)
            begin
                lo = $urandom_range(0, filled - 1);
                hi = $urandom_range(0, filled - 1);
            end
            else
            begin
                lo = clamp_index(next_lo + int'($urandom_range(0, 16)) - 8, filled - 1);
                hi = clamp_index(next_stop - 1 + int'($urandom_range(0, 16)) - 8, filled - 1);
            end
            if (hi < lo)
            begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            ask_range(lo, hi, $urandom_range(0, 65535));
        end
    endtask

    initial
    begin
        int n;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= rdc_pkg::ACTION_LOAD;
        load_index   <= '0;
        load_value   <= '0;
        left_bound   <= '0;
        right_bound  <= '0;
        query_tag    <= '0;
        hold_request <= 1'b0;
        tx_idle_pct  = 22;
        rx_idle_pct  = 46;
        filled       = 0;
        next_lo      = 0;
        next_stop    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part; the first transfer waits out the clearing pass.
        load_element(0, 0);
        load_element(1, rdc_pkg::VALUE_RANGE - 1);
        load_element(2, 5);
        load_element(3, 5);
        load_element(4, 0);
        load_element(5, rdc_pkg::VALUE_RANGE - 1);
        load_element(6, 7);
        load_element(7, 8);
        load_element(8, 9);
        load_element(9, 5);
        load_element(10, 1);
        load_element(11, 2);
        ask_range(0, 11, 16'h0000);
        ask_range(3, 3, 16'hFFFF);
        ask_range(rdc_pkg::ELEMENT_DEPTH - 1, 0, 16'h1234);
        ask_range(5, 4, 16'h00A5);
        ask_range(0, 0, 16'h5A00);
        load_element(0, rdc_pkg::VALUE_RANGE - 1);
        load_element(rdc_pkg::ELEMENT_DEPTH - 1, rdc_pkg::VALUE_RANGE - 1);
        ask_range(0, 11, 16'h0101);
        load_element(6, 5);
        load_element(3, 1000);
        ask_range(2, 8, 16'h0202);
        ask_range(9, 11, 16'h0303);
        ask_range(0, 2, 16'h0404);

        // Long receiver hold-off while the sender keeps offering.
        wait_for_answers();
        hold_request <= 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == PHASE_ITEMS)
            begin
                wait_for_answers();
                tx_idle_pct = 46;
                rx_idle_pct = 22;
            end
            else if (n == 2 * PHASE_ITEMS)
            begin
                wait_for_answers();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_item();
        end

        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
